// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks sampled on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// implication checked in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication checked a fixed number of cycles later
`define ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_DELAY(lbl, ante, n, cons, msg)
`endif
`endif

// ===== hdl/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// shared constants and operation codes of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DEF_WORD_BITS = 32;
	localparam int DEF_FRAC_BITS = 16;
	localparam int FUNC_BITS     = 3;

	typedef enum logic [FUNC_BITS-1:0] {
		FN_ADD  = 3'd0,
		FN_SUB  = 3'd1,
		FN_MUL  = 3'd2,
		FN_DIV  = 3'd3,
		FN_MAG  = 3'd4,
		FN_CONJ = 3'd5,
		FN_CMP  = 3'd6
	} func_t;

endpackage

// ===== hdl/cau_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_mult
// two-stage signed multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
module cau_mult #(
	parameter int W = cau_pkg::DEF_WORD_BITS
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	localparam int H  = W / 2;
	localparam int LW = W - H;
	localparam int PW = 2 * W;

	logic [H-1:0]         al, bl;
	logic signed [LW-1:0] ah, bh;
	logic signed [H:0]    al_x, bl_x;

	logic signed [2*LW-1:0] hh_s2;
	logic signed [W:0]      hl_s2, lh_s2;
	logic [2*H-1:0]         ll_s2;

	logic signed [PW-1:0] hh_x, hl_x, lh_x, ll_x;
	logic signed [PW-1:0] p_s3;

	// split operands: signed upper halves, unsigned lower halves
	assign al   = a[H-1:0];
	assign bl   = b[H-1:0];
	assign ah   = a[W-1:H];
	assign bh   = b[W-1:H];
	assign al_x = {1'b0, al};
	assign bl_x = {1'b0, bl};

	// partial products
	always_ff @(posedge clk) begin
		hh_s2 <= ah * bh;
		hl_s2 <= ah * bl_x;
		lh_s2 <= al_x * bh;
		ll_s2 <= al * bl;
	end

	// align and sum the partial products
	assign hh_x = {{(PW-2*LW){hh_s2[2*LW-1]}}, hh_s2};
	assign hl_x = {{(PW-W-1){hl_s2[W]}}, hl_s2};
	assign lh_x = {{(PW-W-1){lh_s2[W]}}, lh_s2};
	assign ll_x = {{(PW-2*H){1'b0}}, ll_s2};

	always_ff @(posedge clk) begin
		p_s3 <= (hh_x <<< (2*H)) + ((hl_x + lh_x) <<< H) + ll_x;
	end

	assign p = p_s3;

endmodule

// ===== hdl/cau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int W = cau_pkg::DEF_WORD_BITS,
	parameter int F = cau_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic [2*W+F-1:0]   num,
	input  logic [2*W-1:0]     den,
	output logic [W-1:0]       quo,
	output logic               ovf
);

	localparam int NW = 2 * W + F;
	localparam int DW = 2 * W;
	localparam int RW = NW + W;

	logic [NW-1:0] rem_s [0:W-1];
	logic [DW-1:0] den_s [0:W-1];
	logic [W-1:0]  quo_s [0:W];
	logic          ovf_s [0:W];

	// entry stage: quotient does not fit in W bits when num >= den * 2^W
	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= RW'(num) >= (RW'(den) << W);
	end

	// one compare and subtract per stage, msb first
	for (genvar k = 1; k <= W; k++) begin : g_stage
		localparam int I = W - k;
		logic [RW-1:0] trial;
		logic          take;

		assign trial = RW'(den_s[k-1]) << I;
		assign take  = RW'(rem_s[k-1]) >= trial;

		always_ff @(posedge clk) begin
			quo_s[k] <= quo_s[k-1] | (take ? (W'(1) << I) : W'(0));
			ovf_s[k] <= ovf_s[k-1];
		end

		if (k < W) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= take ? NW'(RW'(rem_s[k-1]) - trial) : rem_s[k-1];
				den_s[k] <= den_s[k-1];
			end
		end
	end

	assign quo = quo_s[W];
	assign ovf = ovf_s[W];

endmodule

// ===== hdl/cau_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_sqrt
// pipelined integer square root, one root bit per stage, remainder kept
// ----------------------------------------------------------------------------
module cau_sqrt #(
	parameter int W = cau_pkg::DEF_WORD_BITS
) (
	input  logic             clk,
	input  logic [2*W-1:0]   rad,
	output logic [W-1:0]     root,
	output logic [2*W:0]     rem
);

	localparam int RW = 2 * W + 1;

	logic [RW-1:0] rem_s  [0:W];
	logic [W-1:0]  root_s [0:W];

	// entry stage
	always_ff @(posedge clk) begin
		rem_s[0]  <= RW'(rad);
		root_s[0] <= '0;
	end

	// remainder stays rad - root^2; try setting one bit per stage
	for (genvar k = 1; k <= W; k++) begin : g_stage
		localparam int I = W - k;
		logic [RW-1:0] trial;
		logic          take;

		assign trial = (RW'(root_s[k-1]) << (I + 1)) + (RW'(1) << (2 * I));
		assign take  = rem_s[k-1] >= trial;

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? rem_s[k-1] - trial : rem_s[k-1];
			root_s[k] <= root_s[k-1] | (take ? (W'(1) << I) : W'(0));
		end
	end

	assign root = root_s[W];
	assign rem  = rem_s[W];

endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// a start transfer reaches its done strobe through stages 1 to 4, the divider delay line and the output register
// throughput: one item per cycle; divider and square root retire one bit per stage
// busy is always low since every stage advances each cycle
// reset clears the valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_arithmetic_unit #(
	parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [cau_pkg::FUNC_BITS-1:0]  func,
	input  logic signed [WORD_BITS-1:0]    a_re,
	input  logic signed [WORD_BITS-1:0]    a_im,
	input  logic signed [WORD_BITS-1:0]    b_re,
	input  logic signed [WORD_BITS-1:0]    b_im,
	output logic                           done,
	output logic signed [WORD_BITS-1:0]    res_re,
	output logic signed [WORD_BITS-1:0]    res_im,
	output logic                           equal,
	output logic                           div_zero,
	output logic                           saturated
);

	localparam int W        = WORD_BITS;
	localparam int F        = FRAC_BITS;
	localparam int W1       = W + 1;
	localparam int PW       = 2 * W;
	localparam int SW       = PW + 1;
	localparam int NW       = PW + F;
	localparam int RW       = PW + 1;
	localparam int DONE_LAT = W + 6;

	localparam logic signed [SW-1:0] HALF   = SW'((64'd1 << F) >> 1);
	localparam logic signed [SW-1:0] MAX_SW = (SW'(1) <<< (W - 1)) - SW'(1);
	localparam logic signed [SW-1:0] MIN_SW = -(SW'(1) <<< (W - 1));
	localparam logic [W-1:0]         MAX_W  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]         MIN_W  = {1'b1, {(W-1){1'b0}}};

	// clip to the word range, flag in the top bit
	function automatic logic [W:0] clip(input logic signed [SW-1:0] v);
		logic [W:0] r;
		if (v > MAX_SW) r = {1'b1, MAX_SW[W-1:0]};
		else if (v < MIN_SW) r = {1'b1, MIN_SW[W-1:0]};
		else r = {1'b0, v[W-1:0]};
		return r;
	endfunction

	// sign and clip one quotient magnitude, flag in the top bit
	function automatic logic [W:0] div_part(input logic neg, input logic ovf,
		input logic [W-1:0] q);
		logic [W:0] r;
		if (neg) begin
			if (ovf || q > MIN_W) r = {1'b1, MIN_W};
			else r = {1'b0, W'(~q + W'(1))};
		end else begin
			if (ovf || q > MAX_W) r = {1'b1, MAX_W};
			else r = {1'b0, q};
		end
		return r;
	endfunction

	logic accept;

	// stage 1: operand capture
	logic                   valid_s1;
	cau_pkg::func_t         func_s1;
	logic signed [W-1:0]    a_re_s1, a_im_s1, b_re_s1, b_im_s1;

	// stages 2 and 3: operands wait for the multipliers
	logic                   valid_s2, valid_s3;
	cau_pkg::func_t         func_s2, func_s3;
	logic signed [W-1:0]    a_re_s2, a_im_s2, b_re_s2, b_im_s2;
	logic signed [W-1:0]    a_re_s3, a_im_s3, b_re_s3, b_im_s3;

	logic signed [W-1:0]    sq_x, sq_y;
	logic signed [PW-1:0]   p_rr, p_ii, p_ri, p_ir, p_xx, p_yy;

	// stage 4: product sums and simple results
	logic                   valid_s4;
	cau_pkg::func_t         func_s4;
	logic signed [SW-1:0]   mre_s4, mim_s4, nre_s4, nim_s4;
	logic [PW-1:0]          den_s4;
	logic signed [W:0]      sre_s4, sim_s4;
	logic                   eq_s4, bz_s4;
	logic signed [W:0]      sre, sim;

	// comb after stage 4
	logic signed [SW-1:0]   rnd_re, rnd_im, e_re, e_im;
	logic [W:0]             cr, ci;
	logic                   neg_re, neg_im;
	logic [PW-1:0]          abs_re, abs_im;
	logic [NW-1:0]          num_re, num_im;

	// delay line beside the divider and square root
	logic                   vld_dly_q  [0:W];
	cau_pkg::func_t         func_dly_q [0:W];
	logic [W-1:0]           ere_dly_q  [0:W];
	logic [W-1:0]           eim_dly_q  [0:W];
	logic                   esat_dly_q [0:W];
	logic                   eq_dly_q   [0:W];
	logic                   dz_dly_q   [0:W];
	logic                   nre_dly_q  [0:W];
	logic                   nim_dly_q  [0:W];

	logic [W-1:0]           quo_re, quo_im;
	logic                   ovf_re, ovf_im;
	logic [W-1:0]           sq_root;
	logic [RW-1:0]          sq_rem;

	// final selection
	logic [W:0]             dr, di, rnd_mag;
	logic                   sq_up;
	logic [W-1:0]           f_re, f_im;
	logic                   f_eq, f_dz, f_sat;

	logic                   done_q;
	logic [W-1:0]           res_re_q, res_im_q;
	logic                   equal_q, div_zero_q, saturated_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// input transfer capture
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= cau_pkg::func_t'(func);
			a_re_s1 <= a_re;
			a_im_s1 <= a_im;
			b_re_s1 <= b_re;
			b_im_s1 <= b_im;
		end
	end

	// squares use a for magnitude, b for the divide denominator
	assign sq_x = (func_s1 == cau_pkg::FN_MAG) ? a_re_s1 : b_re_s1;
	assign sq_y = (func_s1 == cau_pkg::FN_MAG) ? a_im_s1 : b_im_s1;

	cau_mult #(.W(W)) u_mul_rr (.clk(clk), .a(a_re_s1), .b(b_re_s1), .p(p_rr));
	cau_mult #(.W(W)) u_mul_ii (.clk(clk), .a(a_im_s1), .b(b_im_s1), .p(p_ii));
	cau_mult #(.W(W)) u_mul_ri (.clk(clk), .a(a_re_s1), .b(b_im_s1), .p(p_ri));
	cau_mult #(.W(W)) u_mul_ir (.clk(clk), .a(a_im_s1), .b(b_re_s1), .p(p_ir));
	cau_mult #(.W(W)) u_mul_xx (.clk(clk), .a(sq_x), .b(sq_x), .p(p_xx));
	cau_mult #(.W(W)) u_mul_yy (.clk(clk), .a(sq_y), .b(sq_y), .p(p_yy));

	// operands follow the multiplier stages
	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		a_re_s2 <= a_re_s1;
		a_im_s2 <= a_im_s1;
		b_re_s2 <= b_re_s1;
		b_im_s2 <= b_im_s1;
		func_s3 <= func_s2;
		a_re_s3 <= a_re_s2;
		a_im_s3 <= a_im_s2;
		b_re_s3 <= b_re_s2;
		b_im_s3 <= b_im_s2;
	end

	// add, subtract and conjugate results
	always_comb begin
		sre = '0;
		sim = '0;
		case (func_s3)
			cau_pkg::FN_ADD: begin
				sre = W1'(a_re_s3) + W1'(b_re_s3);
				sim = W1'(a_im_s3) + W1'(b_im_s3);
			end
			cau_pkg::FN_SUB: begin
				sre = W1'(a_re_s3) - W1'(b_re_s3);
				sim = W1'(a_im_s3) - W1'(b_im_s3);
			end
			cau_pkg::FN_CONJ: begin
				sre = W1'(a_re_s3);
				sim = W1'(0) - W1'(a_im_s3);
			end
			default: begin
				sre = '0;
				sim = '0;
			end
		endcase
	end

	// stage 4 register
	always_ff @(posedge clk) begin
		func_s4 <= func_s3;
		mre_s4  <= SW'(p_rr) - SW'(p_ii);
		mim_s4  <= SW'(p_ri) + SW'(p_ir);
		nre_s4  <= SW'(p_rr) + SW'(p_ii);
		nim_s4  <= SW'(p_ir) - SW'(p_ri);
		den_s4  <= PW'($unsigned(p_xx)) + PW'($unsigned(p_yy));
		sre_s4  <= sre;
		sim_s4  <= sim;
		eq_s4   <= (func_s3 == cau_pkg::FN_CMP) && (a_re_s3 == b_re_s3) && (a_im_s3 == b_im_s3);
		bz_s4   <= (b_re_s3 == '0) && (b_im_s3 == '0);
	end

	// multiply rounding, ties toward plus infinity
	assign rnd_re = (mre_s4 + HALF) >>> F;
	assign rnd_im = (mim_s4 + HALF) >>> F;

	always_comb begin
		e_re = '0;
		e_im = '0;
		case (func_s4)
			cau_pkg::FN_ADD, cau_pkg::FN_SUB, cau_pkg::FN_CONJ: begin
				e_re = SW'(sre_s4);
				e_im = SW'(sim_s4);
			end
			cau_pkg::FN_MUL: begin
				e_re = rnd_re;
				e_im = rnd_im;
			end
			default: begin
				e_re = '0;
				e_im = '0;
			end
		endcase
	end

	assign cr = clip(e_re);
	assign ci = clip(e_im);

	// divide operands: |num| * 2^F plus half the denominator
	assign neg_re = nre_s4[SW-1];
	assign neg_im = nim_s4[SW-1];
	assign abs_re = PW'(neg_re ? -nre_s4 : nre_s4);
	assign abs_im = PW'(neg_im ? -nim_s4 : nim_s4);
	assign num_re = (NW'(abs_re) << F) + NW'(den_s4 >> 1);
	assign num_im = (NW'(abs_im) << F) + NW'(den_s4 >> 1);

	cau_div #(.W(W), .F(F)) u_div_re (
		.clk(clk), .num(num_re), .den(den_s4), .quo(quo_re), .ovf(ovf_re)
	);
	cau_div #(.W(W), .F(F)) u_div_im (
		.clk(clk), .num(num_im), .den(den_s4), .quo(quo_im), .ovf(ovf_im)
	);
	cau_sqrt #(.W(W)) u_sqrt (
		.clk(clk), .rad(den_s4), .root(sq_root), .rem(sq_rem)
	);

	// delay line valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= W; i++) vld_dly_q[i] <= 1'b0;
		end else begin
			vld_dly_q[0] <= valid_s4;
			for (int i = 1; i <= W; i++) vld_dly_q[i] <= vld_dly_q[i-1];
		end
	end

	// delay line payload
	always_ff @(posedge clk) begin
		func_dly_q[0] <= func_s4;
		ere_dly_q[0]  <= cr[W-1:0];
		eim_dly_q[0]  <= ci[W-1:0];
		esat_dly_q[0] <= cr[W] | ci[W];
		eq_dly_q[0]   <= eq_s4;
		dz_dly_q[0]   <= bz_s4 && (func_s4 == cau_pkg::FN_DIV);
		nre_dly_q[0]  <= neg_re;
		nim_dly_q[0]  <= neg_im;
		for (int i = 1; i <= W; i++) begin
			func_dly_q[i] <= func_dly_q[i-1];
			ere_dly_q[i]  <= ere_dly_q[i-1];
			eim_dly_q[i]  <= eim_dly_q[i-1];
			esat_dly_q[i] <= esat_dly_q[i-1];
			eq_dly_q[i]   <= eq_dly_q[i-1];
			dz_dly_q[i]   <= dz_dly_q[i-1];
			nre_dly_q[i]  <= nre_dly_q[i-1];
			nim_dly_q[i]  <= nim_dly_q[i-1];
		end
	end

	// quotient sign and clipping, root rounding
	assign dr      = div_part(nre_dly_q[W], ovf_re, quo_re);
	assign di      = div_part(nim_dly_q[W], ovf_im, quo_im);
	assign sq_up   = sq_rem > RW'(sq_root);
	assign rnd_mag = W1'(sq_root) + W1'(sq_up);

	// result selection
	always_comb begin
		f_re  = ere_dly_q[W];
		f_im  = eim_dly_q[W];
		f_eq  = eq_dly_q[W];
		f_dz  = 1'b0;
		f_sat = esat_dly_q[W];
		case (func_dly_q[W])
			cau_pkg::FN_DIV: begin
				if (dz_dly_q[W]) begin
					f_re  = '0;
					f_im  = '0;
					f_dz  = 1'b1;
					f_sat = 1'b0;
				end else begin
					f_re  = dr[W-1:0];
					f_im  = di[W-1:0];
					f_sat = dr[W] | di[W];
				end
			end
			cau_pkg::FN_MAG: begin
				f_im = '0;
				if (rnd_mag > W1'(MAX_W)) begin
					f_re  = MAX_W;
					f_sat = 1'b1;
				end else begin
					f_re  = rnd_mag[W-1:0];
					f_sat = 1'b0;
				end
			end
			default: begin
				f_re  = ere_dly_q[W];
				f_im  = eim_dly_q[W];
			end
		endcase
	end

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_dly_q[W];
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		res_re_q    <= f_re;
		res_im_q    <= f_im;
		equal_q     <= f_eq;
		div_zero_q  <= f_dz;
		saturated_q <= f_sat;
	end

	assign done      = done_q;
	assign res_re    = res_re_q;
	assign res_im    = res_im_q;
	assign equal     = equal_q;
	assign div_zero  = div_zero_q;
	assign saturated = saturated_q;

	// every transfer comes out after the fixed latency
	`ASSERT_DELAY(a_latency, start && !busy, DONE_LAT, done, "missing done strobe")
	// zero denominator gives a clean zero result
	`ASSERT_IMPL(a_dz_zero, done && div_zero, res_re == '0 && res_im == '0 && !saturated && !equal, "bad zero divide result")
	// compare leaves both parts zero
	`ASSERT_IMPL(a_eq_zero, done && equal, res_re == '0 && res_im == '0 && !div_zero, "bad compare result")
	// a clipped result sits on a rail
	`ASSERT_IMPL(a_sat_rail, done && saturated, res_re == MAX_W || res_re == MIN_W || res_im == MAX_W || res_im == MIN_W, "saturation off rail")

endmodule
